/* sv/assert_macros.svh */
// Assertion helpers for the RTL files that include them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ATL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ATL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/atl_pkg.sv */
`default_nettype none

package atl_pkg;

   localparam int MAX_TOKENS = 10;
   localparam int VALUE_BITS = 64;
   localparam int POS_W      = 4;
   localparam int KIND_W     = 3;
   localparam int PHASE_W    = 3;

   localparam logic [POS_W-1:0] MAX_TOK_CNT = POS_W'(MAX_TOKENS);

   // number parser phases
   localparam logic [PHASE_W-1:0] PH_PREFIX = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HASH   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LEAD   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_SIGNED = 3'd3;
   localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_ZEROX  = 3'd5;
   localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd6;
   localparam logic [PHASE_W-1:0] PH_STOP   = 3'd7;

   // token classes
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd0;
   localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_OPER    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_LABEL   = 3'd6;

   // characters
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;
   localparam logic [7:0] CH_UX     = 8'h58;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LF     = 8'h66;
   localparam logic [7:0] CH_LX     = 8'h78;
   localparam logic [7:0] CH_LZ     = 8'h7A;

   typedef struct packed {
      logic [PHASE_W-1:0]    phase;
      logic                  hex;
      logic                  neg;
      logic                  ovf;
      logic [VALUE_BITS-1:0] acc;    // magnitude so far
      logic [VALUE_BITS-1:0] nacc;   // its two's complement, tracked in step
   } num_state_type;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [VALUE_BITS-1:0] value;
      logic [POS_W-1:0]      pos;
   } token_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
   endfunction

endpackage

`default_nettype wire

/* sv/atl_num.sv */
`default_nettype none

module atl_num (
   input  wire  logic [7:0]             text_byte,
   input  wire  logic                   start,
   input  wire  atl_pkg::num_state_type cur,
   output atl_pkg::num_state_type       nxt
);

   localparam int VW = atl_pkg::VALUE_BITS;

   atl_pkg::num_state_type src;
   atl_pkg::num_state_type fed;
   logic                   digit_ok;
   logic [3:0]             digit_val;
   logic [VW+3:0]          acc_ext;
   logic [VW+3:0]          prod;
   logic [VW+3:0]          dig_ext;
   logic [VW-1:0]          nprod;
   logic [VW-1:0]          dig_nar;

   // a new token parses from a clean state
   always_comb begin
      src = cur;
      if (start) begin
         src = '0;
      end
   end

   always_comb begin
      digit_ok  = 1'b0;
      digit_val = 4'd0;
      if (atl_pkg::is_dec(text_byte)) begin
         digit_ok  = 1'b1;
         digit_val = text_byte[3:0];
      end else if (src.hex &&
                   (((text_byte >= atl_pkg::CH_LA) && (text_byte <= atl_pkg::CH_LF)) ||
                    ((text_byte >= atl_pkg::CH_UA) && (text_byte <= atl_pkg::CH_UF)))) begin
         digit_ok  = 1'b1;
         digit_val = text_byte[3:0] + 4'd9;
      end
   end

   // acc * base + digit, with four guard bits to spot overflow
   always_comb begin
      acc_ext = {4'b0, src.acc};
      dig_ext = {{VW{1'b0}}, digit_val};
      dig_nar = {{(VW-4){1'b0}}, digit_val};
      if (src.hex) begin
         prod  = (acc_ext << 4) + dig_ext;
         nprod = (src.nacc << 4) - dig_nar;
      end else begin
         prod  = (acc_ext << 3) + (acc_ext << 1) + dig_ext;
         nprod = (src.nacc << 3) + (src.nacc << 1) - dig_nar;
      end
   end

   // one digit step
   always_comb begin
      fed = src;
      if (digit_ok) begin
         fed.phase = atl_pkg::PH_DIGITS;
         if (!src.ovf) begin
            if (|prod[VW+3:VW]) begin
               fed.ovf = 1'b1;
            end else begin
               fed.acc  = prod[VW-1:0];
               fed.nacc = nprod;
            end
         end
      end else begin
         fed.phase = atl_pkg::PH_STOP;
      end
   end

   always_comb begin
      nxt = src;
      if (start) begin
         priority if (text_byte == atl_pkg::CH_HASH) begin
            nxt.phase = atl_pkg::PH_HASH;
         end else if (text_byte == atl_pkg::CH_DOLLAR) begin
            nxt.hex   = 1'b1;
            nxt.phase = atl_pkg::PH_LEAD;
         end else if (atl_pkg::is_dec(text_byte)) begin
            nxt = fed;
         end else begin
            nxt.phase = atl_pkg::PH_STOP;
         end
      end else begin
         unique case (src.phase)
            atl_pkg::PH_HASH: begin
               priority if (text_byte == atl_pkg::CH_DOLLAR) begin
                  nxt.hex   = 1'b1;
                  nxt.phase = atl_pkg::PH_LEAD;
               end else if (atl_pkg::is_dec(text_byte)) begin
                  nxt = fed;
               end else begin
                  nxt.ovf   = 1'b1;
                  nxt.neg   = 1'b0;
                  nxt.phase = atl_pkg::PH_STOP;
               end
            end
            atl_pkg::PH_LEAD: begin
               priority if (atl_pkg::is_space(text_byte)) begin
                  nxt = src;
               end else if (text_byte == atl_pkg::CH_PLUS) begin
                  nxt.phase = atl_pkg::PH_SIGNED;
               end else if (text_byte == atl_pkg::CH_MINUS) begin
                  nxt.neg   = 1'b1;
                  nxt.phase = atl_pkg::PH_SIGNED;
               end else if (src.hex && (text_byte == atl_pkg::CH_ZERO)) begin
                  nxt.phase = atl_pkg::PH_ZERO;
               end else begin
                  nxt = fed;
               end
            end
            atl_pkg::PH_SIGNED: begin
               if (src.hex && (text_byte == atl_pkg::CH_ZERO)) begin
                  nxt.phase = atl_pkg::PH_ZERO;
               end else begin
                  nxt = fed;
               end
            end
            atl_pkg::PH_ZERO: begin
               if ((text_byte == atl_pkg::CH_LX) || (text_byte == atl_pkg::CH_UX)) begin
                  nxt.phase = atl_pkg::PH_ZEROX;
               end else begin
                  nxt = fed;
               end
            end
            atl_pkg::PH_ZEROX,
            atl_pkg::PH_DIGITS: begin
               nxt = fed;
            end
            default: begin
               nxt = src;   // prefix and stop: ignore the byte
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* sv/atl_lex.sv */
`default_nettype none

module atl_lex (
   input  wire  logic         clock,
   input  wire  logic         reset,
   input  wire  logic         step,
   input  wire  logic [7:0]   text_byte,
   input  wire  logic         end_of_text,
   output logic               emit,
   output atl_pkg::token_type token
);

   logic                               inside_ff, inside_in;
   logic [atl_pkg::POS_W-1:0]          count_ff, count_in;
   logic [7:0]                         first_ff, first_in;
   logic [7:0]                         last_ff, last_in;
   atl_pkg::num_state_type             num_ff, num_in;
   atl_pkg::num_state_type             num_step;
   atl_pkg::num_state_type             num_tok;

   logic                               start;
   logic                               feed;
   logic                               emit_raw;
   logic                               line_clear;
   logic                               inside_tok;
   logic [atl_pkg::POS_W-1:0]          count_tok;

   atl_num u_num (
      .text_byte (text_byte),
      .start     (start),
      .cur       (num_ff),
      .nxt       (num_step)
   );

   always_comb begin
      start      = 1'b0;
      feed       = 1'b0;
      emit_raw   = 1'b0;
      line_clear = 1'b0;
      priority if (text_byte == atl_pkg::CH_NL) begin
         emit_raw   = inside_ff;
         line_clear = 1'b1;
      end else if (atl_pkg::is_space(text_byte)) begin
         if (inside_ff) begin
            // the last token of a line swallows whitespace
            if (count_ff >= atl_pkg::MAX_TOK_CNT) begin
               feed = 1'b1;
            end else begin
               emit_raw = 1'b1;
            end
         end
      end else if (inside_ff) begin
         feed = 1'b1;
      end else if (count_ff < atl_pkg::MAX_TOK_CNT) begin
         start = 1'b1;
      end
   end

   always_comb begin
      inside_tok = start | (inside_ff & ~emit_raw & ~line_clear);
      emit       = emit_raw | (end_of_text & inside_tok);
      count_tok  = start ? (count_ff + 1'b1) : count_ff;
      first_in   = start ? text_byte : first_ff;
      last_in    = (start | feed) ? text_byte : last_ff;
      num_tok    = (start | feed) ? num_step : num_ff;
      inside_in  = inside_tok & ~emit & ~end_of_text;
      count_in   = (line_clear | end_of_text) ? '0 : count_tok;
      num_in     = num_tok;
      if (emit | end_of_text) begin
         num_in.phase = atl_pkg::PH_PREFIX;
      end
   end

   // classify from the token state after this byte
   always_comb begin
      token.value = '0;
      token.pos   = count_tok - 1'b1;
      priority if (atl_pkg::is_dec(first_in) || (first_in == atl_pkg::CH_HASH) ||
                   (first_in == atl_pkg::CH_DOLLAR)) begin
         token.kind = atl_pkg::KIND_NUMBER;
         priority if ((num_tok.phase == atl_pkg::PH_HASH) || num_tok.ovf) begin
            token.value = '1;
         end else if (num_tok.neg) begin
            token.value = num_tok.nacc;
         end else begin
            token.value = num_tok.acc;
         end
      end else if ((first_in == atl_pkg::CH_STAR) || (first_in == atl_pkg::CH_PLUS) ||
                   (first_in == atl_pkg::CH_MINUS) || (first_in == atl_pkg::CH_SLASH)) begin
         token.kind = atl_pkg::KIND_OPER;
      end else if (first_in == atl_pkg::CH_LPAREN) begin
         token.kind = atl_pkg::KIND_LPAREN;
      end else if (first_in == atl_pkg::CH_RPAREN) begin
         token.kind = atl_pkg::KIND_RPAREN;
      end else if (atl_pkg::is_alpha(first_in)) begin
         token.kind = (last_in == atl_pkg::CH_COLON) ? atl_pkg::KIND_LABEL
                                                     : atl_pkg::KIND_IDENT;
      end else begin
         token.kind = atl_pkg::KIND_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         count_ff  <= '0;
         first_ff  <= '0;
         last_ff   <= '0;
         num_ff    <= '0;
      end else if (step) begin
         inside_ff <= inside_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
         num_ff    <= num_in;
      end
   end

endmodule

`default_nettype wire

/* sv/assembler_token_lexer.sv */
// A byte that ends a token is held in the input register, and its token then
// goes into the result register; the byte waits only behind a stalled one.
// Throughput: one byte per cycle; a byte that ends a token waits only while the
// result register holds an unread token and the consumer stalls.
// The per-byte token and number update is one short combinational step.
// Reset (synchronous, active high) empties both registers and clears line state.
`default_nettype none
`include "assert_macros.svh"

module assembler_token_lexer (
   input  wire  logic                            clock,
   input  wire  logic                            reset,
   input  wire  logic                            req_valid,
   output logic                                  req_ready,
   input  wire  logic [7:0]                      req_text_byte,
   input  wire  logic                            req_end_of_text,
   output logic                                  rsp_valid,
   input  wire  logic                            rsp_ready,
   output logic [atl_pkg::KIND_W-1:0]            rsp_token_kind,
   output logic [atl_pkg::VALUE_BITS-1:0]        rsp_number_value,
   output logic [atl_pkg::POS_W-1:0]             rsp_token_position
);

   // Input register: holds one accepted byte until the lexer consumes it.
   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               in_eot_ff;

   // Result register: holds one finished token until the consumer takes it.
   logic               rsp_valid_ff, rsp_valid_in;
   atl_pkg::token_type rsp_tok_ff;

   logic               advance;
   logic               emit;
   atl_pkg::token_type token;

   atl_lex u_lex (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .text_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .emit        (emit),
      .token       (token)
   );

   // Advance the held byte unless it finishes a token and the result
   // register is still full and stalled. Bytes that emit nothing never wait.
   assign advance   = in_valid_ff & (~emit | ~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on the handshake, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
         in_eot_ff  <= req_end_of_text;
      end
      if (advance && emit) begin
         rsp_tok_ff <= token;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_token_kind     = rsp_tok_ff.kind;
   assign rsp_number_value   = rsp_tok_ff.value;
   assign rsp_token_position = rsp_tok_ff.pos;

   `ATL_ASSERT_NOW(a_non_number_zero, clock, reset,
      rsp_valid_ff && (rsp_tok_ff.kind != atl_pkg::KIND_NUMBER),
      rsp_tok_ff.value == '0, "non-number token carries a value")
   `ATL_ASSERT_NOW(a_position_range, clock, reset, rsp_valid_ff,
      rsp_tok_ff.pos < atl_pkg::MAX_TOK_CNT, "token position beyond line limit")
   `ATL_ASSERT_NEXT(a_byte_held, clock, reset, req_valid && req_ready, in_valid_ff,
      "accepted byte lost before the lexer")
   `ATL_ASSERT_NEXT(a_token_held, clock, reset, advance && emit, rsp_valid_ff,
      "emitted token lost before the result register")

endmodule

`default_nettype wire
